FILE: src/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and codes of the first-fit page allocator: request kinds,
// result status codes, controller states and the command/status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// saturation limit of the used byte count
	localparam logic [18:0] USED_MAX = 19'h7FFFF;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_SIZE_RD,
		ST_CHECK,
		ST_WALK,
		ST_RESP
	} ffpa_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic scan;
		logic find;
		logic size_rd;
		logic check;
		logic walk;
		logic resp;
	} ffpa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic req_alloc;
		logic req_zero;
		logic off_in;
		logic scan_hit;
		logic scan_fail;
		logic find_hit;
		logic size_zero;
		logic walk_last;
	} ffpa_stat_t;

endpackage

FILE: src/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Controller state machine: clearing pass after reset, request intake,
// first-fit scan, page lookup for frees, mark/clear walk and response.
// ----------------------------------------------------------------------------
module ffpa_ctrl
	import ffpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  ffpa_stat_t stat,
	output ffpa_cmd_t  cmd,
	output logic       busy
);

	ffpa_state_t state_q;
	ffpa_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					if (stat.req_alloc) begin
						state_d = stat.req_zero ? ST_RESP : ST_SCAN;
					end else begin
						state_d = stat.off_in ? ST_FIND : ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_hit) begin
					state_d = ST_WALK;
				end else if (stat.scan_fail) begin
					state_d = ST_RESP;
				end
			end
			ST_FIND: begin
				if (stat.find_hit) state_d = ST_SIZE_RD;
			end
			ST_SIZE_RD: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = stat.size_zero ? ST_RESP : ST_WALK;
			end
			ST_WALK: begin
				if (stat.walk_last) state_d = ST_RESP;
			end
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		busy        = 1'b1;
		case (state_q)
			ST_CLEAR:   cmd.clear = 1'b1;
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_SCAN:    cmd.scan = 1'b1;
			ST_FIND:    cmd.find = 1'b1;
			ST_SIZE_RD: cmd.size_rd = 1'b1;
			ST_CHECK:   cmd.check = 1'b1;
			ST_WALK:    cmd.walk = 1'b1;
			ST_RESP:    cmd.resp = 1'b1;
			default:    cmd = '0;
		endcase
	end

endmodule

FILE: src/ffpa_datapath.sv
// ----------------------------------------------------------------------------
// ffpa_datapath
// Page busy and block size stores, scan pointer, run and page accumulators,
// used page counter and the registered result.
// ----------------------------------------------------------------------------
module ffpa_datapath
	import ffpa_pkg::*;
#(
	parameter int PAGE_COUNT = 64,
	parameter int PAGE_BYTES = 4096
)(
	input  logic        clk,
	input  logic        arst_n,
	input  ffpa_cmd_t   cmd,
	output ffpa_stat_t  stat,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        kind,
	input  logic [18:0] request_bytes,
	input  logic [31:0] free_address,
	output logic        done,
	output logic        status,
	output logic [31:0] granted_address,
	output logic [18:0] used_bytes
);

	localparam int PTR_W = $clog2(PAGE_COUNT);
	localparam int ACC_W = $clog2(PAGE_COUNT * PAGE_BYTES + 1);
	localparam int CNT_W = $clog2(PAGE_COUNT + 1);
	localparam logic [PTR_W-1:0] LAST_PAGE = PTR_W'(PAGE_COUNT - 1);
	localparam logic [ACC_W-1:0] PB_ACC    = ACC_W'(PAGE_BYTES);
	localparam logic [32:0]      STORE     = 33'(PAGE_COUNT * PAGE_BYTES);

	// stores, cleared by a sweep after reset
	logic             busy_mem [PAGE_COUNT];
	logic [18:0]      size_mem [PAGE_COUNT];
	logic             busy_rd_q;
	logic [18:0]      size_rd_q;

	logic [31:0]      base_q;
	logic [PTR_W-1:0] ptr_q;
	logic             issue_done_q;
	logic             rd_vld_s1;
	logic [PTR_W-1:0] rd_ptr_s1;
	logic [PTR_W-1:0] run_start_q;
	logic [ACC_W-1:0] run_acc_q;
	logic [ACC_W-1:0] pg_acc_q;
	logic [ACC_W-1:0] off_q;
	logic [CNT_W-1:0] cnt_q;
	logic             kind_q;
	logic [18:0]      bytes_q;
	logic             fail_q;
	logic [31:0]      grant_q;
	logic             done_q;
	logic             status_q;
	logic [31:0]      granted_q;
	logic [18:0]      used_q;

	logic [31:0]      off_full;
	logic [ACC_W:0]   run_sum;
	logic [18:0]      walk_tgt;
	logic             ptr_last;
	logic             busy_we;
	logic             busy_wd;
	logic             size_we;
	logic [PTR_W-1:0] size_wa;
	logic [18:0]      size_wd;
	logic [ACC_W-1:0] used_prod;
	logic [31:0]      start_off;

	// request decode and status
	assign off_full = free_address - base_q;
	assign run_sum  = (ACC_W+1)'(run_acc_q) + (ACC_W+1)'(PAGE_BYTES);
	assign walk_tgt = (kind_q == KIND_FREE) ? size_rd_q : bytes_q;
	assign ptr_last = (ptr_q == LAST_PAGE);

	always_comb begin
		stat           = '0;
		stat.clr_last  = ptr_last;
		stat.req_alloc = (kind == KIND_ALLOC);
		stat.req_zero  = (request_bytes == '0);
		stat.off_in    = ({1'b0, off_full} < STORE);
		stat.scan_hit  = cmd.scan && rd_vld_s1 && !busy_rd_q &&
			(32'(run_sum) >= 32'(bytes_q));
		stat.scan_fail = cmd.scan && rd_vld_s1 && (rd_ptr_s1 == LAST_PAGE) &&
			!stat.scan_hit;
		stat.find_hit  = (32'(off_q) < 32'(pg_acc_q));
		stat.size_zero = (size_rd_q == '0);
		stat.walk_last = (32'(run_sum) >= 32'(walk_tgt)) || ptr_last;
	end

	// store write controls
	always_comb begin
		busy_we = cmd.clear || cmd.walk;
		busy_wd = cmd.walk && (kind_q == KIND_ALLOC);
		size_we = cmd.clear || stat.scan_hit || (cmd.check && !stat.size_zero);
		size_wa = stat.scan_hit ? run_start_q : ptr_q;
		size_wd = stat.scan_hit ? bytes_q : '0;
	end

	// page busy store, one write and one registered read
	always_ff @(posedge clk) begin
		if (busy_we) busy_mem[ptr_q] <= busy_wd;
		busy_rd_q <= busy_mem[ptr_q];
	end

	// block size store
	always_ff @(posedge clk) begin
		if (size_we) size_mem[size_wa] <= size_wd;
		if (cmd.size_rd) size_rd_q <= size_mem[ptr_q];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// pointer, scan pipeline and used page count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			cnt_q        <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan && !issue_done_q;
			if (cmd.accept) begin
				ptr_q        <= '0;
				issue_done_q <= 1'b0;
			end else if (stat.scan_hit) begin
				ptr_q <= run_start_q;
			end else if (cmd.scan) begin
				if (!ptr_last) ptr_q <= ptr_q + PTR_W'(1);
				issue_done_q <= issue_done_q || ptr_last;
			end else if (cmd.clear || cmd.walk || (cmd.find && !stat.find_hit)) begin
				if (!ptr_last) ptr_q <= ptr_q + PTR_W'(1);
			end
			if (cmd.walk) begin
				cnt_q <= (kind_q == KIND_ALLOC) ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);
			end
		end
	end

	// request latch, run tracking and page accumulators
	assign start_off = 32'(run_start_q) * 32'(PAGE_BYTES);

	always_ff @(posedge clk) begin
		rd_ptr_s1 <= ptr_q;
		if (cmd.accept) begin
			kind_q      <= kind;
			bytes_q     <= request_bytes;
			off_q       <= ACC_W'(off_full);
			fail_q      <= (kind == KIND_ALLOC);
			grant_q     <= '0;
			run_acc_q   <= '0;
			run_start_q <= '0;
			pg_acc_q    <= PB_ACC;
		end else if (stat.scan_hit) begin
			fail_q    <= 1'b0;
			grant_q   <= base_q + start_off;
			run_acc_q <= '0;
		end else if (cmd.scan && rd_vld_s1) begin
			if (busy_rd_q) begin
				run_acc_q   <= '0;
				run_start_q <= rd_ptr_s1 + PTR_W'(1);
			end else begin
				run_acc_q <= ACC_W'(run_sum);
			end
		end else if (cmd.find && !stat.find_hit) begin
			pg_acc_q <= pg_acc_q + PB_ACC;
		end else if (cmd.check) begin
			run_acc_q <= '0;
		end else if (cmd.walk) begin
			run_acc_q <= ACC_W'(run_sum);
		end
	end

	// result register
	assign used_prod = ACC_W'(cnt_q) * PB_ACC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.resp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			status_q  <= fail_q ? STATUS_FAIL : STATUS_OK;
			granted_q <= grant_q;
			used_q    <= (32'(used_prod) > 32'(USED_MAX)) ? USED_MAX : 19'(used_prod);
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign used_bytes      = used_q;

endmodule

FILE: src/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Page allocator over PAGE_COUNT pages: first-fit allocate and free by
// address, with one result beat per request.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores with busy high. A request is
// taken when start is high and busy is low; its result beat appears on done
// in the first cycle with busy low again, and cannot be held off. An
// allocate scans the pages one per cycle through the busy store's registered
// read port, then marks the pages of the run; a zero-size allocate goes
// straight to its response. A free steps through the pages up to the
// addressed page, reads its block size and clears the pages of the block; a
// free outside the store goes straight to its response. The page stores are
// walked sequentially, one entry per cycle.
module first_fit_page_allocator
	import ffpa_pkg::*;
#(
	parameter int PAGE_COUNT = 64,
	parameter int PAGE_BYTES = 4096
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [18:0] request_bytes,
	input  logic [31:0] free_address,
	output logic        done,
	output logic        status,
	output logic [31:0] granted_address,
	output logic [18:0] used_bytes
);

	ffpa_cmd_t  cmd;
	ffpa_stat_t stat;

	// controller
	ffpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	ffpa_datapath #(
		.PAGE_COUNT (PAGE_COUNT),
		.PAGE_BYTES (PAGE_BYTES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.kind            (kind),
		.request_bytes   (request_bytes),
		.free_address    (free_address),
		.done            (done),
		.status          (status),
		.granted_address (granted_address),
		.used_bytes      (used_bytes)
	);

	// a result beat only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a request in flight");

	// results never come in consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats back to back");

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// a failed allocation grants no address
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STATUS_FAIL)) |-> (granted_address == '0))
		else $error("failed allocation reports an address");

endmodule

FILE: bench/tb_first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_page_allocator
// Self-checking bench for the first-fit page allocator. Allocate and free
// requests go in as start/busy beats. The bench keeps its own model of the
// page map and the size store, and works out each expected result beat when
// its request is accepted. Every done beat is checked field by field against
// the oldest expectation. A directed pass covers the size limits, the free
// corner cases and address wrap. Random traffic then runs under several base
// addresses, with sender pauses, and a final stretch has no pauses.
// ----------------------------------------------------------------------------
module tb_first_fit_page_allocator;
	import ffpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_COUNT = 64;
	localparam int PAGE_BYTES = 4096;
	localparam int STORE_BYTES = PAGE_COUNT * PAGE_BYTES;
	// worst request: scan of every page plus marking or clearing every page
	localparam int SETTLE_CYCLES = 2 * PAGE_COUNT + 12;

	typedef struct packed {
		logic        status;
		logic [31:0] granted;
		logic [18:0] used;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        start;
	logic        busy;
	logic        kind;
	logic [18:0] request_bytes;
	logic [31:0] free_address;
	logic        done;
	logic        status;
	logic [31:0] granted_address;
	logic [18:0] used_bytes;

	// model of the allocator state
	logic          page_taken [PAGE_COUNT];
	logic [18:0]   page_alloc_bytes [PAGE_COUNT];
	logic [31:0]   region_base;

	alloc_result_t expected_results [$];
	alloc_result_t oldest_result;
	int            mismatch_count;

	first_fit_page_allocator #(
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_BYTES(PAGE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.kind(kind),
		.request_bytes(request_bytes),
		.free_address(free_address),
		.done(done),
		.status(status),
		.granted_address(granted_address),
		.used_bytes(used_bytes)
	);

	// clock, 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// pages needed for a byte count
	function automatic int pages_needed(input logic [18:0] bytes);
		return (int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
	endfunction

	// apply one request to the model and return its result beat
	function automatic alloc_result_t predict_request(input logic k,
			input logic [18:0] bytes, input logic [31:0] addr);
		alloc_result_t r;
		int            need;
		int            first;
		int            page;
		longint        occupied;
		logic [31:0]   offset;
		bit            fits;
		r.status  = STATUS_OK;
		r.granted = '0;
		first = -1;
		if (k == KIND_ALLOC) begin
			need = pages_needed(bytes);
			// lowest run of free pages that is long enough
			if (bytes != 0 && need <= PAGE_COUNT) begin
				for (int s = 0; s + need <= PAGE_COUNT && first < 0; s++) begin
					fits = 1'b1;
					for (int j = 0; j < need; j++)
						if (page_taken[s + j])
							fits = 1'b0;
					if (fits)
						first = s;
				end
			end
			if (first < 0) begin
				r.status = STATUS_FAIL;
			end else begin
				for (int j = 0; j < need; j++)
					page_taken[first + j] = 1'b1;
				page_alloc_bytes[first] = bytes;
				r.granted = region_base + 32'(first) * 32'(PAGE_BYTES);
			end
		end else begin
			offset = addr - region_base;
			if (offset < 32'(STORE_BYTES)) begin
				page = int'(offset / 32'(PAGE_BYTES));
				if (page_alloc_bytes[page] != 0) begin
					need = pages_needed(page_alloc_bytes[page]);
					page_alloc_bytes[page] = '0;
					for (int j = 0; j < need && page + j < PAGE_COUNT; j++)
						page_taken[page + j] = 1'b0;
				end
			end
		end
		occupied = 0;
		for (int i = 0; i < PAGE_COUNT; i++)
			occupied += page_taken[i];
		occupied = occupied * PAGE_BYTES;
		if (occupied > longint'(USED_MAX))
			occupied = longint'(USED_MAX);
		r.used = 19'(occupied);
		return r;
	endfunction

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected beat, expected none, actual status %0d addr %h used %0d",
					$time, status, granted_address, used_bytes);
			end else begin
				oldest_result = expected_results.pop_front();
				if (status !== oldest_result.status) begin
					mismatch_count++;
					$display("%0t: status expected %0d actual %0d",
						$time, oldest_result.status, status);
				end
				if (granted_address !== oldest_result.granted) begin
					mismatch_count++;
					$display("%0t: granted_address expected %h actual %h",
						$time, oldest_result.granted, granted_address);
				end
				if (used_bytes !== oldest_result.used) begin
					mismatch_count++;
					$display("%0t: used_bytes expected %0d actual %0d",
						$time, oldest_result.used, used_bytes);
				end
			end
		end
	end

	// send one request beat; called at a falling edge, returns at one
	task automatic issue_request(input logic k, input logic [18:0] bytes,
			input logic [31:0] addr);
		start = 1'b1;
		kind = k;
		request_bytes = bytes;
		free_address = addr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(predict_request(k, bytes, addr));
		@(negedge clk);
	endtask

	// random sender pause with junk on the request fields
	task automatic maybe_pause(input bit idle_on);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			start = 1'b0;
			kind = 1'($urandom());
			request_bytes = 19'($urandom());
			free_address = $urandom();
			repeat ($urandom_range(1, 11))
				@(negedge clk);
		end
	endtask

	// hold off until every expected beat is in and the block is idle
	task automatic drain_results();
		start = 1'b0;
		while (expected_results.size() != 0 || busy)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic write_base(input logic [31:0] value);
		drain_results();
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = $urandom();
		region_base = value;
	endtask

	// size limits from reset, base address still at its reset value
	task automatic test_alloc_limits();
		issue_request(KIND_ALLOC, 19'd0, 32'h0);
		issue_request(KIND_ALLOC, 19'd262144, 32'h0);
		issue_request(KIND_ALLOC, 19'd1, 32'h0);
		// unaligned free inside the first page releases the whole store
		issue_request(KIND_FREE, 19'h7FFFF, 32'h0000_0FFF);
		issue_request(KIND_ALLOC, 19'h7FFFF, 32'hFFFF_FFFF);
		issue_request(KIND_ALLOC, 19'd262145, 32'h0);
	endtask

	// frees of non-start pages, outside addresses, and first fit over holes
	task automatic test_free_cases();
		issue_request(KIND_ALLOC, 19'd1, 32'h0);
		issue_request(KIND_ALLOC, 19'd4096, 32'h0);
		issue_request(KIND_ALLOC, 19'd4097, 32'h0);
		issue_request(KIND_FREE, 19'd0, 32'h0000_3000);
		issue_request(KIND_FREE, 19'd0, 32'h0004_0000);
		issue_request(KIND_FREE, 19'd0, 32'hFFFF_FFFF);
		issue_request(KIND_FREE, 19'd0, 32'h0000_1000);
		// one-page hole at page 1 is too short for two pages
		issue_request(KIND_ALLOC, 19'd8192, 32'h0);
		issue_request(KIND_ALLOC, 19'd2, 32'h0);
		issue_request(KIND_FREE, 19'd0, 32'h0000_6000);
		issue_request(KIND_FREE, 19'd0, 32'h0000_0000);
		issue_request(KIND_FREE, 19'd0, 32'h0000_1000);
		issue_request(KIND_FREE, 19'd0, 32'h0000_2000);
		issue_request(KIND_FREE, 19'd0, 32'h0000_4000);
	endtask

	// granted address wraps past the top of the address space
	task automatic test_address_wrap();
		write_base(32'hFFFF_F000);
		issue_request(KIND_ALLOC, 19'd1, 32'h0);
		issue_request(KIND_ALLOC, 19'd1, 32'h0);
		issue_request(KIND_FREE, 19'd0, 32'h0000_0000);
		issue_request(KIND_FREE, 19'd0, 32'hFFFF_F000);
	endtask

	// random mix of allocations and frees, the frees mostly aimed at live blocks
	task automatic test_random_traffic(input int count, input bit idle_on);
		int          live_pages [$];
		int          taken_pages;
		int          roll;
		int          pick;
		logic        k;
		logic [18:0] bytes;
		logic [31:0] addr;
		for (int n = 0; n < count; n++) begin
			live_pages.delete();
			taken_pages = 0;
			for (int i = 0; i < PAGE_COUNT; i++) begin
				taken_pages += page_taken[i];
				if (page_alloc_bytes[i] != 0)
					live_pages.push_back(i);
			end
			// keep the store partly full
			roll = $urandom_range(0, 99);
			if (taken_pages > 48)
				k = (roll < 25) ? KIND_ALLOC : KIND_FREE;
			else if (live_pages.size() == 0)
				k = (roll < 80) ? KIND_ALLOC : KIND_FREE;
			else
				k = (roll < 55) ? KIND_ALLOC : KIND_FREE;
			bytes = 19'($urandom());
			addr = $urandom();
			if (k == KIND_ALLOC) begin
				case ($urandom_range(0, 19))
					0: bytes = 19'd0;
					1: bytes = 19'($urandom());
					2: bytes = 19'($urandom_range(16 * PAGE_BYTES + 1, STORE_BYTES));
					default: bytes = 19'($urandom_range(1, 6 * PAGE_BYTES));
				endcase
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70 && live_pages.size() != 0) begin
					pick = live_pages[$urandom_range(0, live_pages.size() - 1)];
					addr = region_base + 32'(pick) * 32'(PAGE_BYTES);
					if ($urandom_range(0, 2) == 0)
						addr = addr + 32'($urandom_range(0, PAGE_BYTES - 1));
				end else if (roll < 85) begin
					addr = region_base + 32'($urandom_range(0, STORE_BYTES - 1));
				end
			end
			maybe_pause(idle_on);
			issue_request(k, bytes, addr);
		end
	endtask

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		kind = KIND_ALLOC;
		request_bytes = '0;
		free_address = '0;
		mismatch_count = 0;
		region_base = '0;
		for (int i = 0; i < PAGE_COUNT; i++) begin
			page_taken[i] = 1'b0;
			page_alloc_bytes[i] = '0;
		end
		repeat (3)
			@(negedge clk);
		arst_n = 1'b1;

		test_alloc_limits();
		test_free_cases();
		test_address_wrap();

		write_base($urandom());
		test_random_traffic(250, 1'b1);
		write_base(32'hFFFF_FFFF);
		test_random_traffic(150, 1'b1);
		write_base(32'h0000_0000);
		test_random_traffic(150, 1'b1);
		write_base($urandom());
		test_random_traffic(150, 1'b0);

		// let the last beats through, then a spell for stray ones
		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/ffpa_pkg.sv
src/ffpa_ctrl.sv
src/ffpa_datapath.sv
src/first_fit_page_allocator.sv
bench/tb_first_fit_page_allocator.sv
